@@ sv/clipped_rect_pixel_writer_unit_defines.svh @@
// Assertion macros shared by the pixel writer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CLIPPED_RECT_PIXEL_WRITER_UNIT_DEFINES_SVH
`define CLIPPED_RECT_PIXEL_WRITER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define CRPW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
// Check a property at every rising edge, reset included.
`define CRPW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");
`else
`define CRPW_ASSERT(lbl, clk, rst_n, prop)
`define CRPW_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/crpw_pkg.sv @@
// Types, widths and codes shared by the pixel writer modules.
// No dependencies.
`default_nettype none
package crpw_pkg;

  localparam int COORD_BITS = 16;
  localparam int COUNT_BITS = 48;

  localparam int POS_W   = COORD_BITS + 1;   // origin + cursor, no wrap
  localparam int SCR_W   = 16;
  localparam int ADDR_W  = 48;
  localparam int COLOR_W = 24;
  localparam int BCNT_W  = 3;
  localparam int WCNT_W  = 48;
  localparam int OP_W    = 2;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 48;

  localparam int PROD_W = POS_W + SCR_W;
  localparam int XOFF_W = POS_W + 2;
  localparam int CMP_W  = (POS_W > SCR_W) ? POS_W : SCR_W;

  localparam int IN_DATA_W  = ((4 * COORD_BITS + COLOR_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ADDR_W + COLOR_W + BCNT_W + WCNT_W + 7) / 8) * 8;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [BCNT_W-1:0] BYTES_3 = BCNT_W'(3);
  localparam logic [BCNT_W-1:0] BYTES_4 = BCNT_W'(4);

  localparam logic [COLOR_W-1:0] COLOR_MASK = 24'hFF_FFFF;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ROW_PITCH     = 3'd2;
  localparam logic [CIDX_W-1:0] REG_FOUR_BYTE     = 3'd3;
  localparam logic [CIDX_W-1:0] REG_DISP_EN       = 3'd4;
  localparam logic [CIDX_W-1:0] REG_VRAM_BASE     = 3'd5;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN = 2'd0,
    OP_PIXEL = 2'd1,
    OP_PUT   = 2'd2
  } op_t;

  // One pixel waiting for address generation
  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pix_t;

  // Screen setup seen by the back end
  typedef struct packed {
    logic [SCR_W-1:0]  screen_width;
    logic [SCR_W-1:0]  screen_height;
    logic [SCR_W-1:0]  row_pitch;
    logic              four_byte;
    logic              disp_en;
    logic [ADDR_W-1:0] vram_base;
  } cfg_t;

  // Finished result
  typedef struct packed {
    logic               write_valid;
    logic [ADDR_W-1:0]  byte_address;
    logic [COLOR_W-1:0] write_data;
    logic [BCNT_W-1:0]  byte_count;
    logic               rect_last;
    logic [WCNT_W-1:0]  written_count;
  } res_t;

endpackage
`default_nettype wire

@@ sv/crpw_front.sv @@
// Front end: decodes requests, walks the rectangle cursor, forms pixel coordinates.
// Depends on crpw_pkg.
`default_nettype none
module crpw_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         acc,
  input  wire crpw_pkg::op_t                op,
  input  wire logic [crpw_pkg::COORD_BITS-1:0] pos_x,
  input  wire logic [crpw_pkg::COORD_BITS-1:0] pos_y,
  input  wire logic [crpw_pkg::COORD_BITS-1:0] rect_w,
  input  wire logic [crpw_pkg::COORD_BITS-1:0] rect_h,
  input  wire logic [crpw_pkg::COLOR_W-1:0]    color,
  output logic                              push,
  output crpw_pkg::pix_t                    pix
);
  import crpw_pkg::*;

  logic [COORD_BITS-1:0] origin_col_r, origin_col_nxt;
  logic [COORD_BITS-1:0] origin_row_r, origin_row_nxt;
  logic [COORD_BITS-1:0] span_w_r, span_w_nxt;
  logic [COORD_BITS-1:0] span_h_r, span_h_nxt;
  logic [COORD_BITS-1:0] cursor_col_r, cursor_col_nxt;
  logic [COORD_BITS-1:0] cursor_row_r, cursor_row_nxt;
  logic                  active_r, active_nxt;

  logic [POS_W-1:0] col_inc;
  logic [POS_W-1:0] row_inc;

  assign col_inc = {1'b0, cursor_col_r} + POS_W'(1);
  assign row_inc = {1'b0, cursor_row_r} + POS_W'(1);

  always_comb begin
    origin_col_nxt = origin_col_r;
    origin_row_nxt = origin_row_r;
    span_w_nxt     = span_w_r;
    span_h_nxt     = span_h_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    active_nxt     = active_r;
    push           = 1'b0;
    pix.x          = {1'b0, origin_col_r} + {1'b0, cursor_col_r};
    pix.y          = {1'b0, origin_row_r} + {1'b0, cursor_row_r};
    pix.color      = color & COLOR_MASK;
    pix.last       = 1'b0;
    case (op)
      OP_BEGIN: begin
        if (acc) begin
          origin_col_nxt = pos_x;
          origin_row_nxt = pos_y;
          span_w_nxt     = rect_w;
          span_h_nxt     = rect_h;
          cursor_col_nxt = '0;
          cursor_row_nxt = '0;
          active_nxt     = (rect_w != '0) && (rect_h != '0);
        end
      end
      OP_PIXEL: begin
        if (acc && active_r) begin
          push = 1'b1;
          if (col_inc >= {1'b0, span_w_r}) begin
            cursor_col_nxt = '0;
            if (row_inc >= {1'b0, span_h_r}) begin
              cursor_row_nxt = '0;
              active_nxt     = 1'b0;
              pix.last       = 1'b1;
            end else begin
              cursor_row_nxt = row_inc[COORD_BITS-1:0];
            end
          end else begin
            cursor_col_nxt = col_inc[COORD_BITS-1:0];
          end
        end
      end
      OP_PUT: begin
        push  = acc;
        pix.x = {1'b0, pos_x};
        pix.y = {1'b0, pos_y};
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_col_r <= '0;
      origin_row_r <= '0;
      span_w_r     <= '0;
      span_h_r     <= '0;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      active_r     <= 1'b0;
    end else begin
      origin_col_r <= origin_col_nxt;
      origin_row_r <= origin_row_nxt;
      span_w_r     <= span_w_nxt;
      span_h_r     <= span_h_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      active_r     <= active_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/crpw_queue.sv @@
// Short pixel queue between front and back ends.
// Depends on crpw_pkg and the assertion macro header.
`default_nettype none
`include "clipped_rect_pixel_writer_unit_defines.svh"
module crpw_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire crpw_pkg::pix_t push_pix,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output crpw_pkg::pix_t      head_pix
);
  import crpw_pkg::*;

  pix_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_pix   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `CRPW_ASSERT(a_q_cnt_bound, clk, rst_n, cnt_r <= Q_CNT_W'(Q_DEPTH))
  `CRPW_ASSERT(a_q_pop_nonempty, clk, rst_n, pop |-> head_valid)
  `CRPW_ASSERT(a_q_push_step, clk, rst_n, (push && !pop) |=> (cnt_r == $past(cnt_r) + Q_CNT_W'(1)))

endmodule
`default_nettype wire

@@ sv/crpw_back.sv @@
// Back end: clips, multiplies out the address, packs data and counts writes.
// Depends on crpw_pkg and the assertion macro header.
`default_nettype none
`include "clipped_rect_pixel_writer_unit_defines.svh"
module crpw_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire crpw_pkg::cfg_t cfg,
  input  wire logic           head_valid,
  input  wire crpw_pkg::pix_t head_pix,
  output logic                pop,
  output logic                res_valid,
  input  wire logic           res_ready,
  output crpw_pkg::res_t      res
);
  import crpw_pkg::*;

  // stage 1: clip decision and partial products
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_keep_r;
  logic [PROD_W-1:0]  s1_prod_r;
  logic [XOFF_W-1:0]  s1_xoff_r;
  logic [COLOR_W-1:0] s1_color_r;
  logic               s1_last_r;

  // output register
  logic               o_valid_r, o_valid_nxt;
  res_t               o_res_r;
  logic [COUNT_BITS-1:0] total_r, total_nxt;

  logic keep;
  logic [XOFF_W-1:0] xoff;
  logic o_load;
  logic s1_load;

  assign o_load  = !o_valid_r || res_ready;
  assign s1_load = !s1_valid_r || o_load;
  assign pop     = head_valid && s1_load;

  assign keep = cfg.disp_en
             && (CMP_W'(head_pix.x) < CMP_W'(cfg.screen_width))
             && (CMP_W'(head_pix.y) < CMP_W'(cfg.screen_height));

  // x*3 as x*2 + x, x*4 as a shift
  assign xoff = cfg.four_byte ? {head_pix.x, 2'b00}
                              : ({1'b0, head_pix.x, 1'b0} + XOFF_W'(head_pix.x));

  assign s1_valid_nxt = s1_load ? head_valid : s1_valid_r;
  assign o_valid_nxt  = o_load ? s1_valid_r : o_valid_r;
  assign total_nxt    = (s1_keep_r) ? total_r + COUNT_BITS'(1) : total_r;

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_keep_r  <= keep;
      s1_prod_r  <= PROD_W'(head_pix.y) * PROD_W'(cfg.row_pitch);
      s1_xoff_r  <= xoff;
      s1_color_r <= head_pix.color;
      s1_last_r  <= head_pix.last;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load && s1_valid_r) begin
      o_res_r.write_valid  <= s1_keep_r;
      o_res_r.byte_address <= s1_keep_r
        ? cfg.vram_base + ADDR_W'(s1_prod_r) + ADDR_W'(s1_xoff_r) : '0;
      o_res_r.write_data   <= s1_keep_r ? s1_color_r : '0;
      o_res_r.byte_count   <= cfg.four_byte ? BYTES_4 : BYTES_3;
      o_res_r.rect_last    <= s1_last_r;
      o_res_r.written_count <= WCNT_W'(total_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
      total_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
      if (o_load && s1_valid_r) begin
        total_r <= total_nxt;
      end
    end
  end

  assign res_valid = o_valid_r;
  assign res       = o_res_r;

  `CRPW_ASSERT(a_back_drop_zero, clk, rst_n, (o_valid_r && !o_res_r.write_valid) |-> (o_res_r.byte_address == '0 && o_res_r.write_data == '0))
  `CRPW_ASSERT(a_back_bytes, clk, rst_n, o_valid_r |-> (o_res_r.byte_count == BYTES_3 || o_res_r.byte_count == BYTES_4))
  `CRPW_ASSERT(a_back_hold, clk, rst_n, (o_valid_r && !res_ready) |=> (o_valid_r && $stable(o_res_r)))

endmodule
`default_nettype wire

@@ sv/clipped_rect_pixel_writer_unit.sv @@
// Clipped rectangle pixel writer: one framebuffer store request per pixel, at one pixel
// per clock while out_tready keeps up. A request enters every cycle while the four-entry
// pixel queue has room; a kept or clipped pixel is written into the queue at the edge
// that accepts it and then passes the queue slot, address stage and output register in
// that order; the output register lets the next request in while a result waits. The
// address stage holds the single y*pitch multiplier; a begin request and reserved opcodes
// give no result. Write configuration only while no request is in flight. Depends on
// crpw_pkg, crpw_front, crpw_queue and crpw_back.
`default_nettype none
module clipped_rect_pixel_writer_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata: pos_x, pos_y, rect_w, rect_h, color (lowest first)
  input  wire logic [crpw_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: opcode
  input  wire logic [crpw_pkg::OP_W-1:0]         in_tuser,
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // tdata: byte_address, write_data, byte_count, written_count (lowest first)
  output logic [crpw_pkg::OUT_DATA_W-1:0]        out_tdata,
  // tuser: write_valid
  output logic                                   out_tuser,
  // tlast: rect_last
  output logic                                   out_tlast,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [crpw_pkg::CIDX_W-1:0]       cfg_index,
  input  wire logic [crpw_pkg::CDATA_W-1:0]      cfg_data
);
  import crpw_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  logic in_acc;
  logic push;
  pix_t push_pix;
  logic q_full;
  logic pop;
  logic head_valid;
  pix_t head_pix;
  res_t res;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_data[SCR_W-1:0];
        REG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_data[SCR_W-1:0];
        REG_ROW_PITCH:     cfg_nxt.row_pitch     = cfg_data[SCR_W-1:0];
        REG_FOUR_BYTE:     cfg_nxt.four_byte     = cfg_data[0];
        REG_DISP_EN:       cfg_nxt.disp_en       = cfg_data[0];
        REG_VRAM_BASE:     cfg_nxt.vram_base     = cfg_data[ADDR_W-1:0];
        default:           cfg_nxt = cfg_r;   // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= '0;
      cfg_r.screen_height <= '0;
      cfg_r.row_pitch     <= '0;
      cfg_r.four_byte     <= 1'b1;
      cfg_r.disp_en       <= 1'b0;
      cfg_r.vram_base     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accept a request whenever the queue has room
  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  crpw_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (in_acc),
    .op     (op_t'(in_tuser)),
    .pos_x  (in_tdata[COORD_BITS-1:0]),
    .pos_y  (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .rect_w (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .rect_h (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .color  (in_tdata[4*COORD_BITS+COLOR_W-1:4*COORD_BITS]),
    .push   (push),
    .pix    (push_pix)
  );

  crpw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_pix   (push_pix),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_pix   (head_pix)
  );

  crpw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_pix   (head_pix),
    .pop        (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  // Pack the result, lowest field first, zero padded to whole bytes
  assign out_tdata = OUT_DATA_W'({res.written_count, res.byte_count,
                                  res.write_data, res.byte_address});
  assign out_tuser = res.write_valid;
  assign out_tlast = res.rect_last;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for clipped_rect_pixel_writer_unit: directed table, then random phases.
// Predicts every framebuffer store from its own model of cursor, clipping and counter state.
// Depends on crpw_pkg and the RTL of the pixel writer only.
`default_nettype none
module testbench;
  import crpw_pkg::*;

  // Reserved opcode: the block must swallow it without a result
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  // Index of the screen setting a directed row runs under
  localparam logic [1:0] AS_RESET     = 2'd0;
  localparam logic [1:0] AT_LIMITS    = 2'd1;
  localparam logic [1:0] SMALL_SCREEN = 2'd2;

  localparam int NUM_ROWS      = 25;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 125;
  localparam int HOLD_CYCLES   = 64;   // long receiver hold-off, fills the pixel queue
  localparam int SETTLE_CYCLES = 8;    // margin for a begin still in flight to settle
  localparam int STALL_LIMIT   = 2000; // cycles without any handshake before giving up
  localparam int REPORT_LIMIT  = 10;

  // One framebuffer store as seen on the result channel
  typedef struct packed {
    logic               write_valid;
    logic [ADDR_W-1:0]  byte_address;
    logic [COLOR_W-1:0] write_data;
    logic [BCNT_W-1:0]  byte_count;
    logic               rect_last;
    logic [WCNT_W-1:0]  written_count;
  } store_t;

  // Screen setting: one value per configuration register
  typedef struct packed {
    logic [15:0]       width;
    logic [15:0]       height;
    logic [15:0]       pitch;
    logic              four_byte;
    logic              enable;
    logic [ADDR_W-1:0] base;
  } setting_t;

  // Directed request; the store is typed in where it is obvious, else predicted
  typedef struct packed {
    logic [1:0]         setting;
    logic [OP_W-1:0]    op;
    logic [15:0]        x;
    logic [15:0]        y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [COLOR_W-1:0] color;
    logic               typed;
    store_t             want;
  } req_row_t;

  localparam store_t PREDICTED    = '0;
  localparam store_t DROPPED      = '{1'b0, 48'h0, 24'h0, BYTES_4, 1'b0, 48'h0};
  localparam store_t DROPPED_LAST = '{1'b0, 48'h0, 24'h0, BYTES_4, 1'b1, 48'h0};
  localparam store_t FIRST_AT_TOP = '{1'b1, 48'hFFFF_FFFF_FFFF, 24'hAB_CDEF, BYTES_4, 1'b0,
                                      48'd1};

  setting_t directed_settings [3] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 48'h0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF},
    '{16'd8,    16'd4,    16'd32,   1'b0, 1'b1, 48'h1000}
  };

  req_row_t directed_rows [NUM_ROWS] = '{
    // after reset: display disabled, empty screen
    '{AS_RESET, OP_PUT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'hFF_FFFF, 1'b1, DROPPED},
    '{AS_RESET, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h11_1111, 1'b0,
      PREDICTED},
    '{AS_RESET, OP_RESERVED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 1'b0,
      PREDICTED},
    '{AS_RESET, OP_BEGIN, 16'h0000, 16'h0000, 16'd2, 16'd1, 24'h00_0000, 1'b0, PREDICTED},
    '{AS_RESET, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h12_3456, 1'b1, DROPPED},
    '{AS_RESET, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h65_4321, 1'b1,
      DROPPED_LAST},
    // largest screen, pitch and base: clip at the far edges, address wraps
    '{AT_LIMITS, OP_PUT, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 24'h00_0000, 1'b1, DROPPED},
    '{AT_LIMITS, OP_PUT, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 24'hFF_FFFF, 1'b1, DROPPED},
    '{AT_LIMITS, OP_PUT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'hAB_CDEF, 1'b1,
      FIRST_AT_TOP},
    '{AT_LIMITS, OP_PUT, 16'hFFFE, 16'hFFFE, 16'h0000, 16'h0000, 24'hFF_FFFF, 1'b0, PREDICTED},
    // rectangle running past the coordinate range, a single put in the middle
    '{AT_LIMITS, OP_BEGIN, 16'hFFFE, 16'hFFFE, 16'd3, 16'd2, 24'h00_0000, 1'b0, PREDICTED},
    '{AT_LIMITS, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h80_0001, 1'b0,
      PREDICTED},
    '{AT_LIMITS, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h7F_FFFE, 1'b0,
      PREDICTED},
    '{AT_LIMITS, OP_PUT, 16'd5, 16'd5, 16'h0000, 16'h0000, 24'h55_AA55, 1'b0, PREDICTED},
    '{AT_LIMITS, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h01_0203, 1'b0,
      PREDICTED},
    '{AT_LIMITS, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h04_0506, 1'b0,
      PREDICTED},
    '{AT_LIMITS, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h07_0809, 1'b0,
      PREDICTED},
    '{AT_LIMITS, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h0A_0B0C, 1'b0,
      PREDICTED},
    // zero-width rectangle opens nothing
    '{AT_LIMITS, OP_BEGIN, 16'd10, 16'd10, 16'd0, 16'd5, 24'h00_0000, 1'b0, PREDICTED},
    '{AT_LIMITS, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'hFF_FFFF, 1'b0,
      PREDICTED},
    // small screen, three-byte pixels, rectangle straddling the corner
    '{SMALL_SCREEN, OP_BEGIN, 16'd7, 16'd3, 16'd2, 16'd2, 24'h00_0000, 1'b0, PREDICTED},
    '{SMALL_SCREEN, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'hC0_FFEE, 1'b0,
      PREDICTED},
    '{SMALL_SCREEN, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'hBE_EF00, 1'b0,
      PREDICTED},
    '{SMALL_SCREEN, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h12_3456, 1'b0,
      PREDICTED},
    '{SMALL_SCREEN, OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'hFE_DCBA, 1'b0,
      PREDICTED}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [OP_W-1:0]      in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CIDX_W-1:0]    cfg_index;
  logic [CDATA_W-1:0]   cfg_data;

  // Shadow of the screen registers, updated as each write is accepted
  logic [15:0]       shadow_width  = '0;
  logic [15:0]       shadow_height = '0;
  logic [15:0]       shadow_pitch  = '0;
  logic              shadow_four   = 1'b1;
  logic              shadow_enable = 1'b0;
  logic [ADDR_W-1:0] shadow_base   = '0;

  // Rectangle walk and written-pixel count as the block should hold them
  logic [15:0]       org_col = '0, org_row = '0;
  logic [15:0]       span_w = '0, span_h = '0;
  logic [15:0]       cur_col = '0, cur_row = '0;
  logic              rect_open = 1'b0;
  logic [WCNT_W-1:0] stores_kept = '0;

  store_t pending_stores [$];
  store_t observed;
  store_t oldest;
  int     counted_requests = 0;
  int     mismatch_count = 0;
  int     idle_cycles = 0;
  bit     steady_flow = 1'b0;   // both sides drop their idling while set
  bit     hold_results = 1'b0;  // asks the receiver for one long hold-off

  clipped_rect_pixel_writer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Form the store for one pixel position under the current screen setting;
  // a kept pixel advances the written count, a dropped one leaves it alone.
  function automatic store_t place_pixel(input logic [16:0] col, input logic [16:0] row,
                                         input logic [COLOR_W-1:0] color, input bit closing);
    logic [63:0] bytes;
    store_t s;
    s = '0;
    bytes = shadow_four ? 64'd4 : 64'd3;
    s.byte_count = shadow_four ? BYTES_4 : BYTES_3;
    s.rect_last = closing;
    if (shadow_enable && col < shadow_width && row < shadow_height) begin
      s.write_valid = 1'b1;
      s.byte_address = ADDR_W'(64'(shadow_base) + 64'(row) * 64'(shadow_pitch)
                               + 64'(col) * bytes);
      s.write_data = color;
      stores_kept = stores_kept + 1'b1;
    end
    s.written_count = stores_kept;
    return s;
  endfunction

  // Advance the predicted state by one accepted request; returns 1 when a store follows.
  function automatic bit forecast_store(input logic [OP_W-1:0] op,
                                        input logic [15:0] px, py, w, h,
                                        input logic [COLOR_W-1:0] color, output store_t res);
    logic [16:0] col, row;
    bit closing;
    bit emits;
    res = '0;
    emits = 1'b0;
    closing = 1'b0;
    case (op)
      OP_BEGIN: begin
        org_col = px;
        org_row = py;
        span_w = w;
        span_h = h;
        cur_col = '0;
        cur_row = '0;
        rect_open = (w != 0) && (h != 0);
        counted_requests++;
      end
      OP_PIXEL: begin
        if (rect_open) begin
          // origin plus cursor carries into bit 16, so such pixels clip
          col = {1'b0, org_col} + {1'b0, cur_col};
          row = {1'b0, org_row} + {1'b0, cur_row};
          cur_col = cur_col + 1'b1;
          if (cur_col >= span_w) begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
            if (cur_row >= span_h) begin
              cur_row = '0;
              rect_open = 1'b0;
              closing = 1'b1;
            end
          end
          res = place_pixel(col, row, color, closing);
          emits = 1'b1;
          counted_requests++;
        end
      end
      OP_PUT: begin
        res = place_pixel({1'b0, px}, {1'b0, py}, color, 1'b0);
        emits = 1'b1;
        counted_requests++;
      end
      default: emits = 1'b0;
    endcase
    return emits;
  endfunction

  // Offer one request after a random gap; predict its store once it is taken.
  // Entered at a falling edge and left at one, with tvalid still high.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [15:0] x, y, w, h,
                              input logic [COLOR_W-1:0] color, input bit typed,
                              input store_t want);
    int gap;
    store_t predicted;
    gap = steady_flow ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {color, h, w, y, x};
    do @(posedge clk); while (!in_tready);
    if (forecast_store(op, x, y, w, h, color, predicted))
      pending_stores.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Write one register and mirror it; cfg_valid stays high on return.
  task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCREEN_WIDTH:  shadow_width  = value[15:0];
      REG_SCREEN_HEIGHT: shadow_height = value[15:0];
      REG_ROW_PITCH:     shadow_pitch  = value[15:0];
      REG_FOUR_BYTE:     shadow_four   = value[0];
      REG_DISP_EN:       shadow_enable = value[0];
      REG_VRAM_BASE:     shadow_base   = value[ADDR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    write_register(REG_SCREEN_WIDTH,  CDATA_W'(s.width));
    write_register(REG_SCREEN_HEIGHT, CDATA_W'(s.height));
    write_register(REG_ROW_PITCH,     CDATA_W'(s.pitch));
    write_register(REG_FOUR_BYTE,     CDATA_W'(s.four_byte));
    write_register(REG_DISP_EN,       CDATA_W'(s.enable));
    write_register(REG_VRAM_BASE,     CDATA_W'(s.base));
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every predicted store, then let a begin still in flight settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_stores.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Screen extent: mostly small so that clipping is common, sometimes an extreme
  function automatic logic [15:0] pick_extent();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic setting_t draw_setting();
    setting_t s;
    s.width  = pick_extent();
    s.height = pick_extent();
    case ($urandom_range(0, 7))
      0: s.pitch = 16'h0000;
      1: s.pitch = 16'hFFFF;
      default: s.pitch = 16'($urandom);
    endcase
    s.four_byte = 1'($urandom_range(0, 1));
    s.enable = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 7))
      0: s.base = '0;
      1: s.base = '1;
      default: s.base = ADDR_W'({$urandom, $urandom});
    endcase
    return s;
  endfunction

  // Coordinate near the screen, so both sides of the edge are hit;
  // now and then right at the top of the range, where origin plus cursor overflows
  function automatic logic [15:0] pick_origin(input logic [15:0] limit);
    int hi;
    if ($urandom_range(0, 15) == 0)
      return 16'hFFFF - 16'($urandom_range(0, 3));
    hi = int'(limit) + 2;
    if (hi > 65535)
      hi = 65535;
    return 16'($urandom_range(0, hi));
  endfunction

  // One random burst: mostly a complete rectangle, else a cut-short one,
  // a single put or a request with every field random
  task automatic send_random_burst();
    int pick;
    int cols, rows, count;
    logic [15:0] ox, oy;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      cols = $urandom_range(1, 6);
      rows = $urandom_range(1, 4);
      ox = pick_origin(shadow_width);
      oy = pick_origin(shadow_height);
      send_request(OP_BEGIN, ox, oy, 16'(cols), 16'(rows), 24'($urandom), 1'b0, PREDICTED);
      count = (pick < 75) ? cols * rows : $urandom_range(0, cols * rows - 1);
      repeat (count)
        send_request(OP_PIXEL, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     24'($urandom), 1'b0, PREDICTED);
    end else if (pick < 93) begin
      send_request(OP_PUT, pick_origin(shadow_width), pick_origin(shadow_height),
                   16'($urandom), 16'($urandom), 24'($urandom), 1'b0, PREDICTED);
    end else begin
      send_request(OP_W'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 24'($urandom), 1'b0, PREDICTED);
    end
  endtask

  // Sender: reset, directed table, random phases, drain, verdict
  initial begin : request_source
    logic [1:0] current;
    int phase_end;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_BEGIN;
    cfg_valid  = 1'b0;
    cfg_index  = REG_SCREEN_WIDTH;
    cfg_data   = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: the first rows run on the reset setting, unwritten
    current = AS_RESET;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].setting != current) begin
        wait_drained();
        apply_setting(directed_settings[directed_rows[i].setting]);
        current = directed_rows[i].setting;
      end
      send_request(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                   directed_rows[i].w, directed_rows[i].h, directed_rows[i].color,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    // Random part: a fresh screen setting per phase, written only once drained.
    // Phase one runs flat out and holds the receiver off once to back the queue up.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      apply_setting(draw_setting());
      steady_flow = (phase == 1) || ($urandom_range(0, 4) == 0);
      if (phase == 1)
        hold_results = 1'b1;
      phase_end = counted_requests + PHASE_ITEMS;
      while (counted_requests < phase_end)
        send_random_burst();
    end

    in_tvalid <= 1'b0;
    while (pending_stores.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_stores.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Receiver: a random stall before each store, or the long hold-off when asked
  initial begin : store_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Compare each accepted store with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      observed.write_valid   = out_tuser;
      observed.byte_address  = out_tdata[0 +: ADDR_W];
      observed.write_data    = out_tdata[ADDR_W +: COLOR_W];
      observed.byte_count    = out_tdata[ADDR_W + COLOR_W +: BCNT_W];
      observed.written_count = out_tdata[ADDR_W + COLOR_W + BCNT_W +: WCNT_W];
      observed.rect_last     = out_tlast;
      if (pending_stores.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected store: valid=%0b addr=%h data=%h bytes=%0d last=%0b count=%h",
                   observed.write_valid, observed.byte_address, observed.write_data,
                   observed.byte_count, observed.rect_last, observed.written_count);
      end else begin
        oldest = pending_stores.pop_front();
        if (observed !== oldest) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("store mismatch: expected valid=%0b addr=%h data=%h bytes=%0d last=%0b count=%h",
                     oldest.write_valid, oldest.byte_address, oldest.write_data,
                     oldest.byte_count, oldest.rect_last, oldest.written_count);
            $display("                actual   valid=%0b addr=%h data=%h bytes=%0d last=%0b count=%h",
                     observed.write_valid, observed.byte_address, observed.write_data,
                     observed.byte_count, observed.rect_last, observed.written_count);
          end
        end
      end
    end
  end

  // Watchdog: give up once no channel has moved for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire

@@ clipped_rect_pixel_writer_unit.f @@
+incdir+sv
sv/crpw_pkg.sv
sv/crpw_front.sv
sv/crpw_queue.sv
sv/crpw_back.sv
sv/clipped_rect_pixel_writer_unit.sv
sim/testbench.sv
